// ===== src/kra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kra_pkg: shared types and constants of the keyed record aggregator
// Holds the sequencer states, the slot record layout and the fixed-point
// conversion constants.
// ----------------------------------------------------------------------------
package kra_pkg;

    localparam int unsigned KEY_W   = 16;
    localparam int unsigned TMS_W   = 44;
    localparam int unsigned SEC_W   = 35;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned KC_W    = 16;
    localparam int unsigned TF_W    = 21;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned TSUM_W  = 48;
    localparam int unsigned PSUM_W  = 40;
    localparam int unsigned SLOT_W  = 6;

    // milliseconds per second, and remainder width for the seconds divider
    localparam int unsigned MS_PER_S = 1000;
    localparam int unsigned REM_W    = 10;
    // 459.67 degrees F scaled by 1000
    localparam int unsigned F_OFFSET_MILLI = 459670;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_UPD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_stat;

    typedef struct packed {
        logic [PSUM_W-1:0]     cloud_sum;
        logic [PSUM_W-1:0]     humidity_sum;
        logic [TSUM_W-1:0]     temp_sum;
        logic [CNT_W-1:0]      snow_count;
        logic [CNT_W-1:0]      lightning_count;
        logic [SEC_W-1:0]      min_time;
        logic signed [TF_W-1:0] lo_temp;
        logic [SEC_W-1:0]      max_time;
        logic signed [TF_W-1:0] hi_temp;
        logic [CNT_W-1:0]      count;
    } t_rec;

endpackage
`default_nettype wire

// ===== src/keyed_record_aggregator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_aggregator: group-by min/max/sum over weather items
// Finds or claims the slot of each item's key and updates its totals.
// ----------------------------------------------------------------------------
// Sequence: after the item is accepted, the slot keys in use are compared
//   against its key one slot key a cycle, stopping at the first hit, beside an
//   11-step seconds divider; then the totals are updated (or the item dropped).
// Flow: one item at a time;
//   the next item is taken the cycle after the result is accepted downstream.
// Reset: synchronous active low; clears the sequencer, fill count and full flag only.
// ----------------------------------------------------------------------------
module keyed_record_aggregator #(
    parameter int unsigned TABLE_SLOTS = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // state_code[15:0], time_ms[59:16], humidity_pct[66:60], snow_flag[67],
    // cloud_pct[74:68], lightning_flag[75], temp_kelvin_centi[91:76], zero pad
    input  wire [95:0]   s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // slot[5:0], record_count[37:6], max_temp_f_milli[58:38],
    // max_time_s[93:59], min_temp_f_milli[114:94], min_time_s[149:115],
    // lightning_count[181:150], snow_count[213:182], temp_sum_centi[261:214],
    // humidity_sum[301:262], cloud_sum[341:302], zero pad
    output logic [343:0] m_axis_tdata,
    // table_full[0]
    output logic         m_axis_tuser
);

    localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

    kra_pkg::t_state r_state;

    // latched item fields
    logic [kra_pkg::KEY_W-1:0]     r_key;
    logic [kra_pkg::PCT_W-1:0]     r_hum;
    logic [kra_pkg::PCT_W-1:0]     r_cloud;
    logic                          r_snow;
    logic                          r_light;
    logic [kra_pkg::KC_W-1:0]      r_kc;
    logic signed [kra_pkg::TF_W-1:0] r_tf;

    logic [CW-1:0]                 r_used;
    logic [AW-1:0]                 r_slot;
    logic                          r_new;
    logic                          r_full;

    kra_pkg::t_rec                 r_mem [TABLE_SLOTS];
    kra_pkg::t_rec                 r_rd;
    kra_pkg::t_rec                 upd;
    kra_pkg::t_rec                 r_out;

    kra_pkg::t_scan_stat           scan_stat;
    logic [AW-1:0]                 scan_slot;
    logic                          div_done;
    logic [kra_pkg::SEC_W-1:0]     secs;
    logic                          start;
    logic                          work_done;
    logic                          claim;
    logic [AW-1:0]                 rd_addr;
    logic [kra_pkg::TF_W:0]        tf_wide;

    assign s_axis_tready = (r_state == kra_pkg::S_IDLE);
    assign start         = s_axis_tvalid && s_axis_tready;
    assign work_done     = (r_state == kra_pkg::S_SCAN) && scan_stat.done && div_done;
    assign claim         = work_done && !scan_stat.found
                           && (r_used < CW'(TABLE_SLOTS));
    assign rd_addr       = scan_slot;

    // F*1000 = kc*18 - 459670, exact; kc*18 as two shifts
    assign tf_wide = ({6'd0, s_axis_tdata[91:76]} << 4)
                   + ({6'd0, s_axis_tdata[91:76]} << 1)
                   - (kra_pkg::TF_W+1)'(kra_pkg::F_OFFSET_MILLI);

    kra_sec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_ms    (s_axis_tdata[59:16]),
        .o_done  (div_done),
        .o_sec   (secs)
    );

    // compare against the held key; the input bus may change after acceptance
    kra_key_scan #(
        .SLOTS (TABLE_SLOTS),
        .AW    (AW),
        .CW    (CW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_key     (r_key),
        .i_used    (r_used),
        .i_wr_en   (claim),
        .i_wr_addr (r_used[AW-1:0]),
        .i_wr_key  (r_key),
        .o_stat    (scan_stat),
        .o_slot    (scan_slot)
    );

    // saturating adds; stored values never exceed their top
    function automatic logic [kra_pkg::CNT_W-1:0] sat_cnt(
        input logic [kra_pkg::CNT_W-1:0] a, input logic b);
        logic [kra_pkg::CNT_W:0] s;
        s = {1'b0, a} + {{kra_pkg::CNT_W{1'b0}}, b};
        return s[kra_pkg::CNT_W] ? '1 : s[kra_pkg::CNT_W-1:0];
    endfunction

    function automatic logic [kra_pkg::PSUM_W-1:0] sat_pct(
        input logic [kra_pkg::PSUM_W-1:0] a, input logic [kra_pkg::PCT_W-1:0] b);
        logic [kra_pkg::PSUM_W:0] s;
        s = {1'b0, a} + (kra_pkg::PSUM_W+1)'(b);
        return s[kra_pkg::PSUM_W] ? '1 : s[kra_pkg::PSUM_W-1:0];
    endfunction

    // build the slot's new totals: fresh record on claim, else accumulate
    always_comb begin
        upd = r_rd;
        if (r_new) begin
            upd.count           = kra_pkg::CNT_W'(1);
            upd.hi_temp         = r_tf;
            upd.max_time        = secs;
            upd.lo_temp         = r_tf;
            upd.min_time        = secs;
            upd.lightning_count = kra_pkg::CNT_W'(r_light);
            upd.snow_count      = kra_pkg::CNT_W'(r_snow);
            upd.temp_sum        = kra_pkg::TSUM_W'(r_kc);
            upd.humidity_sum    = kra_pkg::PSUM_W'(r_hum);
            upd.cloud_sum       = kra_pkg::PSUM_W'(r_cloud);
        end else begin
            upd.count = sat_cnt(r_rd.count, 1'b1);
            // ties keep the time stored by the earlier item
            if (r_tf > r_rd.hi_temp) begin
                upd.hi_temp  = r_tf;
                upd.max_time = secs;
            end
            if (r_tf < r_rd.lo_temp) begin
                upd.lo_temp  = r_tf;
                upd.min_time = secs;
            end
            upd.lightning_count = sat_cnt(r_rd.lightning_count, r_light);
            upd.snow_count      = sat_cnt(r_rd.snow_count, r_snow);
            upd.temp_sum        = ({1'b0, r_rd.temp_sum} + (kra_pkg::TSUM_W+1)'(r_kc))
                                  > {1'b0, {kra_pkg::TSUM_W{1'b1}}}
                                  ? '1 : r_rd.temp_sum + kra_pkg::TSUM_W'(r_kc);
            upd.humidity_sum    = sat_pct(r_rd.humidity_sum, r_hum);
            upd.cloud_sum       = sat_pct(r_rd.cloud_sum, r_cloud);
        end
    end

    // totals memory: registered read, write on update
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (r_state == kra_pkg::S_UPD) begin
            r_mem[r_slot] <= upd;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_key   <= s_axis_tdata[15:0];
            r_hum   <= s_axis_tdata[66:60];
            r_snow  <= s_axis_tdata[67];
            r_cloud <= s_axis_tdata[74:68];
            r_light <= s_axis_tdata[75];
            r_kc    <= s_axis_tdata[91:76];
            r_tf    <= tf_wide[kra_pkg::TF_W-1:0];
        end
        if (work_done) begin
            r_slot <= scan_stat.found ? scan_slot : r_used[AW-1:0];
            r_new  <= !scan_stat.found;
        end
        if (r_state == kra_pkg::S_UPD) begin
            r_out <= upd;
        end else if (work_done && !scan_stat.found && !claim) begin
            r_out <= '0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kra_pkg::S_IDLE;
            r_used  <= '0;
            r_full  <= 1'b0;
        end else begin
            case (r_state)
                kra_pkg::S_IDLE: begin
                    if (start) begin
                        r_state <= kra_pkg::S_SCAN;
                    end
                end
                kra_pkg::S_SCAN: begin
                    if (work_done) begin
                        if (scan_stat.found) begin
                            r_full  <= 1'b0;
                            r_state <= kra_pkg::S_UPD;
                        end else if (claim) begin
                            r_full  <= 1'b0;
                            r_used  <= r_used + 1'b1;
                            r_state <= kra_pkg::S_UPD;
                        end else begin
                            // no free slot: drop the item, flag it
                            r_full  <= 1'b1;
                            r_state <= kra_pkg::S_OUT;
                        end
                    end
                end
                kra_pkg::S_UPD: begin
                    r_state <= kra_pkg::S_OUT;
                end
                kra_pkg::S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= kra_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= kra_pkg::S_IDLE;
                end
            endcase
        end
    end

    logic [5:0] out_slot;
    assign out_slot = r_full ? 6'd0 : 6'(r_slot);

    assign m_axis_tvalid = (r_state == kra_pkg::S_OUT);
    assign m_axis_tuser  = r_full;
    assign m_axis_tdata  = {2'b00,
                            r_out.cloud_sum,
                            r_out.humidity_sum,
                            r_out.temp_sum,
                            r_out.snow_count,
                            r_out.lightning_count,
                            r_out.min_time,
                            r_out.lo_temp,
                            r_out.max_time,
                            r_out.hi_temp,
                            r_out.count,
                            out_slot};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("dropped item carries nonzero totals");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(TABLE_SLOTS))
        else $error("slot fill count beyond table size");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while a result is pending");

    a_claim_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        claim |=> r_used == $past(r_used) + 1'b1)
        else $error("slot claim did not advance fill count");

endmodule
`default_nettype wire

// ===== src/kra_sec_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kra_sec_div: milliseconds to whole seconds
// Divide by 1000 four dividend bits per cycle; each quotient digit comes from
// a small reciprocal multiply, the remainder from a compare-free subtract.
// ----------------------------------------------------------------------------
module kra_sec_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [kra_pkg::TMS_W-1:0]   i_ms,
    output logic                       o_done,
    output logic [kra_pkg::SEC_W-1:0]  o_sec
);

    localparam int unsigned DIG_W  = 4;
    localparam int unsigned STEPS  = kra_pkg::TMS_W / DIG_W;
    localparam int unsigned CW     = $clog2(STEPS + 1);
    localparam int unsigned PART_W = kra_pkg::REM_W + DIG_W;
    // ceil(2^24 / 1000): the digit is exact for every partial below 16000
    localparam int unsigned RECIP  = 16778;
    localparam int unsigned SH     = 24;
    localparam int unsigned PROD_W = SH + DIG_W;

    logic [kra_pkg::TMS_W-1:0] r_dvd, n_dvd;
    logic [kra_pkg::REM_W-1:0] r_rem, n_rem;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [PART_W-1:0]         part;
    logic [PROD_W-1:0]         prod;
    logic [DIG_W-1:0]          qd;
    logic [PART_W-1:0]         back;
    logic [PART_W-1:0]         diff;

    always_comb begin
        // shift the next digit under the remainder, estimate, subtract
        part  = {r_rem, r_dvd[kra_pkg::TMS_W-1 -: DIG_W]};
        prod  = PROD_W'(part) * PROD_W'(RECIP);
        qd    = prod[SH +: DIG_W];
        back  = PART_W'(qd) * PART_W'(kra_pkg::MS_PER_S);
        diff  = part - back;
        n_dvd = r_dvd;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_start) begin
            n_dvd = i_ms;
            n_rem = '0;
            n_cnt = CW'(STEPS);
        end else if (r_cnt != '0) begin
            n_rem = diff[kra_pkg::REM_W-1:0];
            n_dvd = {r_dvd[kra_pkg::TMS_W-DIG_W-1:0], qd};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_sec  = r_dvd[kra_pkg::SEC_W-1:0];

endmodule
`default_nettype wire

// ===== src/kra_key_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kra_key_scan: slot key memory and serial key search
// Reads one slot key a cycle and compares it against the item key.
// ----------------------------------------------------------------------------
module kra_key_scan #(
    parameter int unsigned SLOTS = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned CW    = 7
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [kra_pkg::KEY_W-1:0]   i_key,
    input  wire [CW-1:0]               i_used,
    input  wire                        i_wr_en,
    input  wire [AW-1:0]               i_wr_addr,
    input  wire [kra_pkg::KEY_W-1:0]   i_wr_key,
    output kra_pkg::t_scan_stat        o_stat,
    output logic [AW-1:0]              o_slot
);

    logic [kra_pkg::KEY_W-1:0] r_mem [SLOTS];
    logic [kra_pkg::KEY_W-1:0] r_rd_key;
    logic [CW-1:0]             r_idx;
    logic [AW-1:0]             r_cmp_idx;
    logic                      r_cmp_v;
    logic                      r_busy;
    logic                      r_done;
    logic                      r_found;
    logic                      issue;
    logic                      hit;

    assign issue = r_busy && (r_idx < i_used);
    assign hit   = r_busy && r_cmp_v && (r_rd_key == i_key);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_key;
        end
        r_rd_key <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_found   <= 1'b0;
            r_cmp_v   <= 1'b0;
            r_idx     <= '0;
            r_cmp_idx <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_cmp_v <= 1'b0;
            r_idx   <= '0;
        end else if (r_busy) begin
            r_cmp_v   <= issue;
            r_cmp_idx <= r_idx[AW-1:0];
            if (hit) begin
                // stop on the first matching slot
                r_busy    <= 1'b0;
                r_done    <= 1'b1;
                r_found   <= 1'b1;
                r_cmp_idx <= r_cmp_idx;
            end else if (!issue && !r_cmp_v) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.found = r_found;
    assign o_slot       = r_cmp_idx;

endmodule
`default_nettype wire

// ===== sim/kra_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kra_scoreboard: prediction and comparison for the keyed record aggregator
// Watches both stream channels, keeps its own slot table, predicts the slot
// totals each accepted item yields and compares them with the results.
// ----------------------------------------------------------------------------
module kra_scoreboard (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    input  wire          s_axis_tready,
    input  wire [95:0]   s_axis_tdata,
    input  wire          m_axis_tvalid,
    input  wire          m_axis_tready,
    input  wire [343:0]  m_axis_tdata,
    input  wire          m_axis_tuser,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results_seen,
    output int           o_full_seen
);

    localparam int SLOTS = 64;

    typedef struct packed {
        logic                       full;
        logic [kra_pkg::SLOT_W-1:0] slot;
        kra_pkg::t_rec              rec;
    } t_totals;

    logic [kra_pkg::KEY_W-1:0] key_tab [SLOTS];
    kra_pkg::t_rec             rec_tab [SLOTS];
    int                        fill;
    t_totals                   totals_q [$];

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, int w);
        logic [63:0] top;
        top = (64'd1 << w) - 64'd1;
        if (a > top || b > top - a) return top;
        return a + b;
    endfunction

    task automatic aggregate(input logic [95:0] d);
        logic [kra_pkg::KEY_W-1:0]       key;
        logic [kra_pkg::SEC_W-1:0]       secs;
        logic [63:0]                     hum, cld, kc;
        logic                            snow, lit;
        logic signed [kra_pkg::TF_W-1:0] tf;
        int                              s;
        t_totals                         t;
        key  = d[15:0];
        secs = kra_pkg::SEC_W'(d[59:16] / 44'd1000);
        hum  = 64'(d[66:60]);
        snow = d[67];
        cld  = 64'(d[74:68]);
        lit  = d[75];
        kc   = 64'(d[91:76]);
        tf   = kra_pkg::TF_W'(int'(kc) * 18 - 459670);
        s = -1;
        t = '0;
        for (int i = 0; i < fill; i++)
            if (s < 0 && key_tab[i] == key) s = i;
        if (s < 0 && fill >= SLOTS) begin
            t.full = 1'b1;
            totals_q.push_back(t);
            return;
        end
        if (s < 0) begin
            s = fill++;
            key_tab[s] = key;
            rec_tab[s].count = kra_pkg::CNT_W'(1);
            rec_tab[s].hi_temp = tf;
            rec_tab[s].max_time = secs;
            rec_tab[s].lo_temp = tf;
            rec_tab[s].min_time = secs;
            rec_tab[s].lightning_count = kra_pkg::CNT_W'(lit);
            rec_tab[s].snow_count = kra_pkg::CNT_W'(snow);
            rec_tab[s].temp_sum = kra_pkg::TSUM_W'(kc);
            rec_tab[s].humidity_sum = kra_pkg::PSUM_W'(hum);
            rec_tab[s].cloud_sum = kra_pkg::PSUM_W'(cld);
        end else begin
            rec_tab[s].count = kra_pkg::CNT_W'(sat_sum(64'(rec_tab[s].count), 64'd1,
                                                       int'(kra_pkg::CNT_W)));
            // ties keep the time stored by the earlier item
            if (tf > rec_tab[s].hi_temp) begin
                rec_tab[s].hi_temp = tf;
                rec_tab[s].max_time = secs;
            end
            if (tf < rec_tab[s].lo_temp) begin
                rec_tab[s].lo_temp = tf;
                rec_tab[s].min_time = secs;
            end
            rec_tab[s].lightning_count = kra_pkg::CNT_W'(sat_sum(
                64'(rec_tab[s].lightning_count), 64'(lit), int'(kra_pkg::CNT_W)));
            rec_tab[s].snow_count = kra_pkg::CNT_W'(sat_sum(
                64'(rec_tab[s].snow_count), 64'(snow), int'(kra_pkg::CNT_W)));
            rec_tab[s].temp_sum = kra_pkg::TSUM_W'(sat_sum(
                64'(rec_tab[s].temp_sum), kc, int'(kra_pkg::TSUM_W)));
            rec_tab[s].humidity_sum = kra_pkg::PSUM_W'(sat_sum(
                64'(rec_tab[s].humidity_sum), hum, int'(kra_pkg::PSUM_W)));
            rec_tab[s].cloud_sum = kra_pkg::PSUM_W'(sat_sum(
                64'(rec_tab[s].cloud_sum), cld, int'(kra_pkg::PSUM_W)));
        end
        t.slot = kra_pkg::SLOT_W'(s);
        t.rec = rec_tab[s];
        totals_q.push_back(t);
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    task automatic compare_result(input logic [343:0] d, input logic full);
        t_totals e;
        if (totals_q.size() == 0) begin
            $error("result with no item outstanding");
            o_fail_count++;
            return;
        end
        e = totals_q.pop_front();
        check_field("table_full", 64'(e.full), 64'(full));
        check_field("slot", 64'(e.slot), 64'(d[5:0]));
        check_field("record_count", 64'(e.rec.count), 64'(d[37:6]));
        // temperatures compared as raw field bits
        check_field("max_temp_f_milli", 64'({e.rec.hi_temp}), 64'(d[58:38]));
        check_field("max_time_s", 64'(e.rec.max_time), 64'(d[93:59]));
        check_field("min_temp_f_milli", 64'({e.rec.lo_temp}), 64'(d[114:94]));
        check_field("min_time_s", 64'(e.rec.min_time), 64'(d[149:115]));
        check_field("lightning_count", 64'(e.rec.lightning_count), 64'(d[181:150]));
        check_field("snow_count", 64'(e.rec.snow_count), 64'(d[213:182]));
        check_field("temp_sum_centi", 64'(e.rec.temp_sum), 64'(d[261:214]));
        check_field("humidity_sum", 64'(e.rec.humidity_sum), 64'(d[301:262]));
        check_field("cloud_sum", 64'(e.rec.cloud_sum), 64'(d[341:302]));
        if (full) o_full_seen++;
        o_results_seen++;
    endtask

    initial begin
        o_fail_count = 0;
        o_results_seen = 0;
        o_full_seen = 0;
        o_pending = 0;
        fill = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) aggregate(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) compare_result(m_axis_tdata, m_axis_tuser);
        end
        o_pending = totals_q.size();
    end

endmodule

// ===== sim/tb_keyed_record_aggregator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_record_aggregator: stimulus and verdict for the aggregator
// Feeds directed extremes, then random records over a growing key set until
// the slot table overflows; random gaps on both channels, one long stall.
// ----------------------------------------------------------------------------
module tb_keyed_record_aggregator;

    localparam int WATCHDOG_CYCLES = 20000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    wire          s_axis_tready;
    logic [95:0]  s_axis_tdata;
    wire          m_axis_tvalid;
    logic         m_axis_tready;
    wire  [343:0] m_axis_tdata;
    wire          m_axis_tuser;
    int           fail_count, pending, results_seen, full_seen;
    int           idle_cycles;
    int           items_sent;
    logic         long_stall;
    logic [kra_pkg::KEY_W-1:0] key_pool [16];

    keyed_record_aggregator dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    kra_scoreboard checker_i (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen), .o_full_seen(full_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        // mostly short gaps, an occasional long one
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [95:0] pack_item(logic [15:0] key, logic [43:0] tms,
                                              logic [6:0] hum, logic snow,
                                              logic [6:0] cld, logic lit,
                                              logic [15:0] kc);
        return {4'b0, kc, lit, cld, snow, hum, tms, key};
    endfunction

    // offer one item and hold it until accepted; drop valid only for a gap
    task automatic send_item(input logic [95:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    function automatic logic [43:0] rand_tms();
        return 44'({$urandom(), $urandom()});
    endfunction

    // receiver: random back-pressure, one long hold-off near the start
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        while (1) begin
            if (long_stall) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(negedge i_clk);
                long_stall = 1'b0;
            end
            m_axis_tready <= 1'b1;
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_CYCLES) begin
            $display("[keyed_record_aggregator] ERROR");
            $finish;
        end
    end

    initial begin
        logic [15:0] k;
        idle_cycles   = 0;
        items_sent    = 0;
        long_stall    = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes of every field, ties, out-of-range percents
        send_item(pack_item(16'h0000, 44'h0, 7'd0, 1'b0, 7'd0, 1'b0, 16'h0000));
        send_item(pack_item(16'h0000, 44'hFFF_FFFF_FFFF, 7'd127, 1'b1, 7'd127, 1'b1,
                            16'hFFFF));
        send_item(pack_item(16'h0000, 44'd999, 7'd100, 1'b1, 7'd100, 1'b0, 16'hFFFF));
        send_item(pack_item(16'h0000, 44'd1000, 7'd55, 1'b0, 7'd3, 1'b1, 16'h0000));
        send_item(pack_item(16'hFFFF, 44'd123456789, 7'd50, 1'b0, 7'd50, 1'b0,
                            16'd29315));
        send_item(pack_item(16'hFFFF, 44'd987654321, 7'd51, 1'b1, 7'd49, 1'b1,
                            16'd29315));
        send_item(pack_item(16'h5458, 44'h555_5555_5555, 7'h55, 1'b1, 7'h2A, 1'b0,
                            16'h5555));
        send_item(pack_item(16'hAAAA, 44'hAAA_AAAA_AAAA, 7'h2A, 1'b0, 7'h55, 1'b1,
                            16'hAAAA));
        send_item(pack_item(16'h5458, 44'd1, 7'd0, 1'b0, 7'd0, 1'b0, 16'd27315));

        // random: keys from a small pool first so slots accumulate deeply,
        // then a wide key spread that fills and overflows the table
        for (int i = 0; i < 16; i++) key_pool[i] = 16'($urandom());
        for (int n = 0; n < 1350; n++) begin
            if (n == 40) long_stall = 1'b1;
            if (n < 700 || $urandom_range(0, 1) == 0)
                k = key_pool[$urandom_range(0, 15)];
            else
                k = 16'($urandom_range(0, 199));
            send_item(pack_item(k, rand_tms(), 7'($urandom()), 1'($urandom()),
                                7'($urandom_range(0, 1) ? $urandom_range(0, 100)
                                                        : $urandom()),
                                1'($urandom()), 16'($urandom())));
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        $display("Sent %0d records, checked %0d results, %0d dropped on a full table.",
                 items_sent, results_seen, full_seen);
        if (fail_count == 0 && pending == 0)
            $display("[keyed_record_aggregator] OK");
        else
            $display("[keyed_record_aggregator] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/kra_pkg.sv
src/kra_sec_div.sv
src/kra_key_scan.sv
src/keyed_record_aggregator.sv
sim/kra_scoreboard.sv
sim/tb_keyed_record_aggregator.sv
